>>> hdl/wns_pkg.sv
package wns_pkg;

  // Neighbourhood and number format
  localparam int unsigned MaxElements = 4096;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned IdxW        = (MaxElements > 1) ? $clog2(MaxElements) : 1;

  // Field widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned StepW    = 17;
  localparam int unsigned DiffW    = 24;
  localparam int unsigned ExpW     = 3;
  localparam int unsigned SumW     = 64;
  localparam int unsigned RampW    = IdxW + StepW;
  localparam int unsigned WeightW  = RampW + 1;
  localparam int unsigned LinProdW = SampleW + 1 + WeightW;

  // Unity weight in Q.16
  localparam int unsigned OneQ16 = 65536;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Queue between front and back
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoAw    = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_EXP    = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLAMP_EN   = 3'd0,
    CFG_CLAMP_MAX  = 3'd1,
    CFG_MODE       = 3'd2,
    CFG_RAMP_DIR   = 3'd3,
    CFG_RAMP_STEP  = 3'd4,
    CFG_DIFF_BASE  = 3'd5,
    CFG_DIFF_EXP   = 3'd6,
    CFG_SUPPRESS   = 3'd7
  } cfg_idx_e;

  // How the back end turns a sample into a term
  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_ZERO = 2'd1,
    KIND_LIN  = 2'd2,
    KIND_EXP  = 2'd3
  } kind_e;

  typedef struct packed {
    logic               clamp_en;
    logic [SampleW-1:0] clamp_max;
    mode_e              mode;
    logic               ramp_dir;
    logic [StepW-1:0]   ramp_step;
    logic [DiffW-1:0]   diff_base;
    logic [ExpW-1:0]    diff_exp;
    logic               suppress;
  } cfg_t;

  typedef struct packed {
    kind_e                      kind;
    logic [SampleW-1:0]         sample;
    logic signed [WeightW-1:0]  weight;
    logic [DiffW-1:0]           diff;
    logic                       last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

>>> hdl/wns_front.sv
module wns_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wns_pkg::cfg_t         cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [15:0]           sample_i,
  input  logic                  last_i,
  input  wns_pkg::fifo_status_t fifo_status_i,
  output logic                  push_o,
  output wns_pkg::job_t         job_o
);
  import wns_pkg::*;

  logic [IdxW-1:0]           idx_q, idx_d;
  logic [SampleW-1:0]        smp;
  logic [DiffW-1:0]          smp8;
  logic                      base_ge;
  logic [RampW-1:0]          ramp;
  logic signed [WeightW-1:0] ramp_s;

  assign in_ready_o = !fifo_status_i.full;
  assign push_o     = in_valid_i && !fifo_status_i.full;

  // Clamp, then classify the sample for the back end
  always_comb begin
    smp     = (cfg_i.clamp_en && (sample_i > cfg_i.clamp_max)) ? cfg_i.clamp_max : sample_i;
    smp8    = {smp, 8'h00};
    base_ge = cfg_i.diff_base >= smp8;
    ramp    = RampW'(idx_q) * RampW'(cfg_i.ramp_step);
    ramp_s  = $signed({1'b0, ramp});

    job_o.sample = smp;
    job_o.last   = last_i;
    job_o.diff   = base_ge ? (cfg_i.diff_base - smp8) : (smp8 - cfg_i.diff_base);
    job_o.weight = cfg_i.ramp_dir ? ramp_s : ($signed(WeightW'(OneQ16)) - ramp_s);

    unique case (cfg_i.mode)
      MODE_LINEAR: job_o.kind = KIND_LIN;
      MODE_EXP:    job_o.kind = (cfg_i.suppress && base_ge) ? KIND_ZERO : KIND_EXP;
      default:     job_o.kind = KIND_PASS;
    endcase
  end

  // Advance the element index, hold at the top, drop to zero after the last beat
  always_comb begin
    idx_d = idx_q;
    if (push_o) begin
      if (last_i) begin
        idx_d = '0;
      end else if (idx_q != IdxW'(MaxElements - 1)) begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

>>> hdl/wns_fifo.sv
module wns_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  wns_pkg::job_t         job_i,
  input  logic                  pop_i,
  output wns_pkg::job_t         head_o,
  output wns_pkg::fifo_status_t status_o
);
  import wns_pkg::*;

  job_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]   cnt_q;

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = cnt_q == (FifoAw + 1)'(FifoDepth);
  assign status_o.empty = cnt_q == '0;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> hdl/wns_back.sv
module wns_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wns_pkg::cfg_t         cfg_i,
  input  wns_pkg::fifo_status_t fifo_status_i,
  input  wns_pkg::job_t         head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [63:0]           weighted_sum_o
);
  import wns_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_LIN     = 6'b000010,
    ST_MUL_LO  = 6'b000100,
    ST_MUL_HI  = 6'b001000,
    ST_MUL_ADD = 6'b010000,
    ST_ACC     = 6'b100000
  } state_e;

  localparam int unsigned LinUp = (FracBits >= 16) ? FracBits - 16 : 0;
  localparam int unsigned LinDn = (FracBits < 16) ? 16 - FracBits : 0;
  localparam logic [SumW-1:0] SumMax = {1'b0, {(SumW - 1){1'b1}}};
  localparam logic [SumW-1:0] SumMin = {1'b1, {(SumW - 1){1'b0}}};
  localparam int unsigned PloW = 32 + DiffW;
  localparam int unsigned PhiW = 31 + DiffW;

  state_e                     state_q, state_d;
  job_t                       job_q, job_d;
  logic [ExpW-1:0]            cnt_q, cnt_d;
  logic [SumW-1:0]            term_q, term_d;
  logic [PloW-1:0]            plo_q, plo_d;
  logic [PhiW-1:0]            phi_q, phi_d;
  logic [SumW-1:0]            acc_q, acc_d;
  logic                       out_valid_q, out_valid_d;
  logic [SumW-1:0]            out_q, out_d;

  logic signed [LinProdW-1:0] lin_prod;
  logic signed [SumW-1:0]     lin_ext;
  logic [SumW-1:0]            lin_mag;
  logic [SumW-1:0]            lin_term;
  logic [SumW-1:0]            exp_sum;
  logic                       exp_sat;
  logic [SumW:0]              add_wide;
  logic [SumW-1:0]            add_sat;
  logic                       slot_free;

  assign out_valid_o    = out_valid_q;
  assign weighted_sum_o = out_q;
  assign slot_free      = !out_valid_q || out_ready_i;

  // Linear term: signed product rescaled to the output fraction
  always_comb begin
    lin_prod = $signed({1'b0, job_q.sample}) * job_q.weight;
    lin_ext  = SumW'(lin_prod);
    lin_mag  = lin_ext[SumW-1] ? (~lin_ext + 1'b1) : lin_ext;
    if (FracBits >= 16) begin
      lin_term = lin_ext <<< LinUp;
    end else if (lin_ext[SumW-1]) begin
      lin_term = ~(lin_mag >> LinDn) + 1'b1;
    end else begin
      lin_term = lin_mag >> LinDn;
    end
  end

  // Combine the two partial products of one power step, floor by 2^8
  always_comb begin
    exp_sum = {1'b0, phi_q[38:0], 24'h000000} + SumW'(plo_q >> 8);
    exp_sat = (|phi_q[PhiW-1:39]) || exp_sum[SumW-1];
  end

  // Saturating accumulate
  always_comb begin
    add_wide = {acc_q[SumW-1], acc_q} + {term_q[SumW-1], term_q};
    if (add_wide[SumW] != add_wide[SumW-1]) begin
      add_sat = add_wide[SumW] ? SumMin : SumMax;
    end else begin
      add_sat = add_wide[SumW-1:0];
    end
  end

  // Sequence one job at a time
  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    cnt_d       = cnt_q;
    term_d      = term_q;
    plo_d       = plo_q;
    phi_d       = phi_q;
    acc_d       = acc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (!fifo_status_i.empty) begin
          pop_o = 1'b1;
          job_d = head_i;
          unique case (head_i.kind)
            KIND_PASS: begin
              term_d  = SumW'(head_i.sample) << FracBits;
              state_d = ST_ACC;
            end
            KIND_ZERO: begin
              term_d  = '0;
              state_d = ST_ACC;
            end
            KIND_LIN: begin
              state_d = ST_LIN;
            end
            KIND_EXP: begin
              term_d  = SumW'(1) << FracBits;
              cnt_d   = cfg_i.diff_exp;
              state_d = (cfg_i.diff_exp == '0) ? ST_ACC : ST_MUL_LO;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_LIN: begin
        term_d  = lin_term;
        state_d = ST_ACC;
      end
      ST_MUL_LO: begin
        plo_d   = PloW'(term_q[31:0]) * PloW'(job_q.diff);
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        phi_d   = PhiW'(term_q[62:32]) * PhiW'(job_q.diff);
        state_d = ST_MUL_ADD;
      end
      ST_MUL_ADD: begin
        if (exp_sat) begin
          term_d  = SumMax;
          state_d = ST_ACC;
        end else begin
          term_d  = exp_sum;
          cnt_d   = cnt_q - 1'b1;
          state_d = (cnt_q == ExpW'(1)) ? ST_ACC : ST_MUL_LO;
        end
      end
      ST_ACC: begin
        if (!job_q.last) begin
          acc_d   = add_sat;
          state_d = ST_IDLE;
        end else if (slot_free) begin
          out_d       = add_sat;
          out_valid_d = 1'b1;
          acc_d       = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    term_q <= term_d;
    plo_q  <= plo_d;
    phi_q  <= phi_d;
    out_q  <= out_d;
  end

`ifndef ASSERT_OFF
  a_power_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_ADD) |-> (cnt_q != '0))
    else $error("power step without a remaining count");

  a_emit_clears_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC && job_q.last && slot_free) |=> (out_valid_q && acc_q == '0))
    else $error("closing beat did not emit and clear the accumulator");

  a_lin_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIN) |-> (job_q.kind == KIND_LIN))
    else $error("linear step on a job of another kind");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE && !fifo_status_i.empty))
    else $error("queue popped while busy or empty");
`endif

endmodule

>>> hdl/weighted_neighbourhood_sum.sv
// Weighted neighbourhood sum.
// Samples of one neighbourhood arrive as beats on the input channel
// (in_valid_i/in_ready_o, sample_i, last_i); last_i marks the closing beat.
// Each sample is optionally clamped, weighted (pass, linear ramp or
// exponential difference) and added into a saturating 64-bit accumulator.
// On the closing beat the signed Q47.16 total leaves as one beat on the
// output channel (out_valid_o/out_ready_i, weighted_sum_o).
// Configuration is written through cfg_valid_i/cfg_index_i/cfg_data_i; the
// user must write only while the block is idle (the block does not check).
// cfg_ready_o is always high. A front stage classifies each beat into a
// two-entry queue; the back end takes one job at a time. Pass and suppressed
// samples go straight to accumulate, a linear one takes a weight step first,
// and an exponential one repeats a low product, high product and combine
// step per exponent. Reset clears the accumulator, element index, queue and
// output valid flag and loads the register defaults. A stalled receiver
// holds the result; the back end then waits on the next closing beat, and
// the queue backs up the input.
module weighted_neighbourhood_sum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sample_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] weighted_sum_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import wns_pkg::*;

  cfg_t         cfg_q, cfg_d;
  job_t         push_job, head_job;
  logic         push, pop;
  fifo_status_t fifo_status;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CLAMP_EN:  cfg_d.clamp_en  = cfg_data_i[0];
        CFG_CLAMP_MAX: cfg_d.clamp_max = cfg_data_i[SampleW-1:0];
        CFG_MODE:      cfg_d.mode      = mode_e'(cfg_data_i[1:0]);
        CFG_RAMP_DIR:  cfg_d.ramp_dir  = cfg_data_i[0];
        CFG_RAMP_STEP: cfg_d.ramp_step = cfg_data_i[StepW-1:0];
        CFG_DIFF_BASE: cfg_d.diff_base = cfg_data_i[DiffW-1:0];
        CFG_DIFF_EXP:  cfg_d.diff_exp  = cfg_data_i[ExpW-1:0];
        CFG_SUPPRESS:  cfg_d.suppress  = cfg_data_i[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clamp_en  <= 1'b0;
      cfg_q.clamp_max <= '1;
      cfg_q.mode      <= MODE_NONE;
      cfg_q.ramp_dir  <= 1'b0;
      cfg_q.ramp_step <= StepW'(OneQ16);
      cfg_q.diff_base <= '0;
      cfg_q.diff_exp  <= ExpW'(1);
      cfg_q.suppress  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wns_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .last_i        (last_i),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .job_o         (push_job)
  );

  wns_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .head_o   (head_job),
    .status_o (fifo_status)
  );

  wns_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .fifo_status_i  (fifo_status),
    .head_i         (head_job),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .weighted_sum_o (weighted_sum_o)
  );

endmodule
